/* sv/rfb_pkg.sv */
// Shared widths, types and helpers for the resonator filter bank.
// Holds the coefficient table builder that runs at elaboration.
// No dependencies.
package rfb_pkg;

    localparam int SampleW   = 16;
    localparam int BandW     = 6;
    localparam int RespW     = 32;
    localparam int StateW    = 40;
    localparam int CoefW     = 36;
    localparam int BankDepth = 64;
    localparam int NumCoefs  = 5;

    localparam int DefBands        = 64;
    localparam int DefSampleRateHz = 44100;
    localparam int DefLowestFreqHz = 440;

    // coefficient slots in one table row
    localparam int CoefA11 = 0;
    localparam int CoefA12 = 1;
    localparam int CoefA21 = 2;
    localparam int CoefA22 = 3;
    localparam int CoefG   = 4;

    localparam logic [63:0] OneQ32    = 64'h1_0000_0000;
    localparam logic [63:0] TwoPiQ32  = 64'd26986075409;
    localparam logic [63:0] PiQ32     = 64'd13493037705;
    localparam logic signed [63:0] OneQ30 = 64'sd1073741824;
    localparam logic [63:0] FreqFloor = 64'd4294967;
    localparam logic [63:0] FreqCeil  = 64'd257698037760;
    localparam logic [63:0] DecayCap  = 64'd17179869184;

    typedef logic signed [CoefW-1:0] t_coef;
    typedef logic [NumCoefs-1:0][CoefW-1:0] t_coef_set;
    typedef logic [BankDepth-1:0][NumCoefs*CoefW-1:0] t_rom;

    typedef struct packed {
        logic load;
        logic rd;
        logic sub;
        logic mul1;
        logic acc1;
        logic mul2;
        logic acc2;
        logic resp;
        logic advance;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_sts;

    function automatic logic [63:0] umul32(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[95:32];
    endfunction

    // restoring division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] rem;
        int i;
        q = '0;
        rem = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d}) begin
                rem = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        v = v_in;
        res = '0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] pow10q(input logic [63:0] y);
        logic [63:0] y2;
        logic [63:0] y4;
        logic [63:0] y8;
        y2 = umul32(y, y);
        y4 = umul32(y2, y2);
        y8 = umul32(y4, y4);
        return umul32(y8, y2);
    endfunction

    function automatic logic signed [63:0] smul30(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p >>> 30;
    endfunction

    function automatic logic [63:0] clamp_freq(input logic [63:0] f);
        if (f < FreqFloor) return FreqFloor;
        if (f > FreqCeil) return FreqCeil;
        return f;
    endfunction

    function automatic logic [63:0] next_freq(input logic [63:0] f);
        logic [63:0] f2;
        logic [63:0] f3;
        logic [63:0] pos;
        logic [63:0] neg;
        f2 = umul32(f, f);
        f3 = umul32(f2, f);
        pos = (64'd7 * f3) / 64'd10000 + (64'd10041 * f) / 64'd10000
            + (64'd6935 << 32) / 64'd10000000;
        neg = (64'd3 * f2) / 64'd1000;
        return clamp_freq((pos > neg) ? pos - neg : 64'd0);
    endfunction

    function automatic t_coef_set build_band(input logic [63:0] f, input logic [63:0] rate);
        logic [63:0] w, w3, y, cand, t, r, s, k, rho, frac, ang, a2, term, x, ex, e, gq;
        logic signed [63:0] ssum, csum, sn, cs, e30, k30, c30, s30, ks;
        logic signed [63:0] v11, v12, v21, v22, vg;
        t_coef_set cset;
        int b;
        int n;
        w = umul32(f, TwoPiQ32);
        w3 = umul32(umul32(w, w), w);
        y = '0;
        for (b = 34; b >= 0; b--) begin
            cand = y | (64'd1 << b);
            if (pow10q(cand) <= w3) y = cand;
        end
        if (y == 0) y = 64'd1;
        t = udiv64(64'd10 << 58, 64'd127 * y);
        r = (t > (OneQ32 >> 6)) ? OneQ32 : (t << 6);
        s = isqrt64((OneQ32 - umul32(r, r) / 64'd4) << 32);
        k = udiv64(r << 31, s);
        rho = udiv64(f * 64'd1000, rate);
        frac = umul32(rho, s) & 64'hFFFF_FFFF;
        ang = umul32(frac & 64'h3FFF_FFFF, TwoPiQ32);
        a2 = umul32(ang, ang);
        term = ang;
        ssum = $signed(ang);
        for (n = 1; n <= 12; n++) begin
            term = udiv64(umul32(term, a2), 64'((2 * n) * (2 * n + 1)));
            if ((n % 2) == 1) ssum = ssum - $signed(term);
            else ssum = ssum + $signed(term);
        end
        term = OneQ32;
        csum = $signed(OneQ32);
        for (n = 1; n <= 12; n++) begin
            term = udiv64(umul32(term, a2), 64'((2 * n - 1) * (2 * n)));
            if ((n % 2) == 1) csum = csum - $signed(term);
            else csum = csum + $signed(term);
        end
        unique case (frac[31:30])
            2'd0: begin sn = ssum;  cs = csum;  end
            2'd1: begin sn = csum;  cs = -ssum; end
            2'd2: begin sn = -ssum; cs = -csum; end
            default: begin sn = -csum; cs = ssum; end
        endcase
        x = umul32(umul32(r, PiQ32), rho);
        if (x > DecayCap) x = DecayCap;
        ex = OneQ32;
        term = OneQ32;
        for (n = 1; n <= 30; n++) begin
            term = udiv64(umul32(term, x), 64'(n));
            ex = ex + term;
        end
        e = udiv64(64'hFFFF_FFFF_FFFF_FFFF, ex);
        e30 = $signed({2'b00, e[63:2]});
        k30 = $signed({2'b00, k[63:2]});
        c30 = cs >>> 2;
        s30 = sn >>> 2;
        ks = smul30(k30, s30);
        v11 = smul30(e30, c30 + ks);
        v12 = smul30(e30, s30);
        v22 = smul30(e30, c30 - ks);
        v21 = -smul30(smul30(e30, OneQ30 + smul30(k30, k30)), s30);
        gq = umul32(r, TwoPiQ32);
        vg = $signed({2'b00, gq[63:2]});
        cset[CoefA11] = v11[CoefW-1:0];
        cset[CoefA12] = v12[CoefW-1:0];
        cset[CoefA21] = v21[CoefW-1:0];
        cset[CoefA22] = v22[CoefW-1:0];
        cset[CoefG]   = vg[CoefW-1:0];
        return cset;
    endfunction

    function automatic t_rom build_rom(input int nb, input int rate_hz, input int lowest_hz);
        t_rom rom;
        logic [63:0] f;
        logic [63:0] rate;
        int i;
        rate = (rate_hz < 1) ? 64'd1 : 64'(rate_hz);
        f = clamp_freq((64'(lowest_hz) << 32) / 64'd1000);
        for (i = 0; i < BankDepth; i++) begin
            if (i < nb) begin
                rom[i] = build_band(f, rate);
                f = next_freq(f);
            end else begin
                rom[i] = '0;
            end
        end
        return rom;
    endfunction

    // floor(coef * v / 2^30) from the high and low partial products
    function automatic logic signed [46:0] mulc_fin(input logic signed [55:0] ph,
                                                    input logic signed [56:0] pl);
        logic signed [76:0] sum;
        sum = $signed({{1{ph[55]}}, ph, 20'd0}) + 77'(pl);
        return sum[76:30];
    endfunction

    function automatic logic signed [StateW-1:0] sat40(input logic signed [47:0] v);
        if (v > 48'sd549755813887) return 40'sh7F_FFFF_FFFF;
        if (v < -48'sd549755813888) return 40'sh80_0000_0000;
        return v[StateW-1:0];
    endfunction

    function automatic logic signed [RespW-1:0] sat32(input logic signed [46:0] v);
        if (v > 47'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -47'sd2147483648) return 32'sh8000_0000;
        return v[RespW-1:0];
    endfunction

endpackage

/* sv/rfb_ifs.sv */
// Valid/ready channel interfaces for sample words and band response words.
// Depends on rfb_pkg for field widths.
interface rfb_in_if import rfb_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SampleW-1:0] sample_value;
    logic                      input_channel;

    modport source (output valid, output sample_value, output input_channel, input ready);
    modport sink (input valid, input sample_value, input input_channel, output ready);
endinterface

interface rfb_out_if import rfb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [BandW-1:0]        band_index;
    logic signed [RespW-1:0] band_response;
    logic                    last_band;

    modport source (output valid, output band_index, output band_response,
                    output last_band, input ready);
    modport sink (input valid, input band_index, input band_response,
                  input last_band, output ready);
endinterface

/* sv/rfb_ctrl.sv */
// Sequencer for the resonator bank: steps each band through read, subtract,
// two multiply passes and the response pass. Depends on rfb_pkg.
module rfb_ctrl import rfb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_channel,
    input  logic    i_target_channel,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_SUB  = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_ACC1 = 3'd4;
    localparam logic [2:0] S_MUL2 = 3'd5;
    localparam logic [2:0] S_ACC2 = 3'd6;
    localparam logic [2:0] S_RESP = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                // words on the other channel are taken and dropped
                if (i_in_valid && (i_in_channel == i_target_channel)) begin
                    o_cmd.load = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = S_ACC1;
            end
            S_ACC1: begin
                o_cmd.acc1 = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_ACC2;
            end
            S_ACC2: begin
                o_cmd.acc2 = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                // hold until the output register can take the word
                if (i_sts.out_free) begin
                    o_cmd.resp = 1'b1;
                    if (i_sts.last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* sv/rfb_datapath.sv */
// Resonator datapath: state memory, coefficient table, two shared coefficient
// multipliers and the output register. Depends on rfb_pkg and rfb_ifs.
module rfb_datapath import rfb_pkg::*; #(
    parameter int BANDS          = DefBands,
    parameter int SAMPLE_RATE_HZ = DefSampleRateHz,
    parameter int LOWEST_FREQ_HZ = DefLowestFreqHz
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic signed [SampleW-1:0] i_sample_value,
    output t_dp_sts                   o_sts,
    rfb_out_if.source                 o_out
);

    localparam int NumBands = (BANDS < 1) ? 1 : ((BANDS > BankDepth) ? BankDepth : BANDS);
    localparam logic [BandW-1:0] LastBand = BandW'(NumBands - 1);
    localparam t_rom RomTab = build_rom(NumBands, SAMPLE_RATE_HZ, LOWEST_FREQ_HZ);

    logic [2*StateW-1:0]      mem [BankDepth];
    logic [BankDepth-1:0]     r_valid;
    logic [2*StateW-1:0]      r_rd;
    logic                     r_rdv;
    logic [BandW-1:0]         r_band;
    logic signed [StateW-1:0] r_u;
    logic signed [StateW-1:0] r_c;
    logic signed [StateW-1:0] r_q;
    logic signed [StateW-1:0] r_np;
    logic signed [55:0]       r_ph0, r_ph1;
    logic signed [56:0]       r_pl0, r_pl1;
    logic                     r_ov;
    logic [BandW-1:0]         r_out_band;
    logic signed [RespW-1:0]  r_out_resp;
    logic                     r_out_last;

    t_coef_set                cset;
    t_coef                    coef0, coef1;
    logic signed [StateW-1:0] val0, val1;
    logic signed [StateW-1:0] p_cur, q_cur;
    logic signed [46:0]       t0, t1;
    logic signed [StateW-1:0] n_np, n_nq, n_c;
    logic signed [55:0]       n_ph0, n_ph1;
    logic signed [56:0]       n_pl0, n_pl1;
    logic                     out_free;

    assign cset = RomTab[r_band];

    always_comb begin
        coef0 = i_cmd.mul1 ? $signed(cset[CoefA11])
              : (i_cmd.mul2 ? $signed(cset[CoefA21]) : $signed(cset[CoefG]));
        val0  = (i_cmd.mul1 || i_cmd.mul2) ? r_c : r_np;
        coef1 = i_cmd.mul1 ? $signed(cset[CoefA12]) : $signed(cset[CoefA22]);
        val1  = r_q;
        n_ph0 = 56'(coef0) * 56'($signed(val0[StateW-1:20]));
        n_pl0 = 57'(coef0) * 57'($signed({1'b0, val0[19:0]}));
        n_ph1 = 56'(coef1) * 56'($signed(val1[StateW-1:20]));
        n_pl1 = 57'(coef1) * 57'($signed({1'b0, val1[19:0]}));
    end

    assign t0 = mulc_fin(r_ph0, r_pl0);
    assign t1 = mulc_fin(r_ph1, r_pl1);

    assign p_cur = r_rdv ? $signed(r_rd[2*StateW-1:StateW]) : '0;
    assign q_cur = r_rdv ? $signed(r_rd[StateW-1:0]) : '0;
    assign n_c   = sat40(48'(p_cur) - 48'(r_u));
    assign n_np  = sat40(48'(t0) + 48'(t1) + 48'(r_u));
    assign n_nq  = sat40(48'(t0) + 48'(t1));

    assign out_free = !r_ov || o_out.ready;
    assign o_sts.out_free = out_free;
    assign o_sts.last = (r_band == LastBand);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd <= mem[r_band];
        end
        if (i_cmd.acc2) begin
            mem[r_band] <= {r_np, n_nq};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ov    <= 1'b0;
            r_band  <= '0;
        end else begin
            if (i_cmd.acc2) begin
                r_valid[r_band] <= 1'b1;
            end
            if (i_cmd.load) begin
                r_band <= '0;
            end else if (i_cmd.advance) begin
                r_band <= r_band + 1'b1;
            end
            if (i_cmd.resp) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_u <= StateW'($signed({i_sample_value, 16'd0}));
        end
        if (i_cmd.rd) begin
            r_rdv <= r_valid[r_band];
        end
        if (i_cmd.sub) begin
            r_c <= n_c;
            r_q <= q_cur;
        end
        if (i_cmd.mul1 || i_cmd.mul2 || i_cmd.acc2) begin
            r_ph0 <= n_ph0;
            r_pl0 <= n_pl0;
            r_ph1 <= n_ph1;
            r_pl1 <= n_pl1;
        end
        if (i_cmd.acc1) begin
            r_np <= n_np;
        end
        if (i_cmd.resp) begin
            r_out_band <= r_band;
            r_out_resp <= sat32(t0);
            r_out_last <= (r_band == LastBand);
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.band_index    = r_out_band;
    assign o_out.band_response = r_out_resp;
    assign o_out.last_band     = r_out_last;

endmodule

/* sv/resonator_filter_bank.sv */
// A sample word is taken in the idle state; each band then steps through read,
// subtract, two multiply and accumulate passes and the response pass, and the
// next sample is taken only after the last band, as the two shared coefficient
// multipliers are used in three passes per band.
// Output stalls hold the sequence; words on the other channel are taken and dropped.
// Reset (synchronous, active low) zeroes all resonator state and the channel.
module resonator_filter_bank import rfb_pkg::*; #(
    parameter int BANDS          = DefBands,
    parameter int SAMPLE_RATE_HZ = DefSampleRateHz,
    parameter int LOWEST_FREQ_HZ = DefLowestFreqHz
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    rfb_in_if.sink      i_in,
    rfb_out_if.source   o_out
);

    logic    r_target_channel;
    t_dp_cmd cmd;
    t_dp_sts sts;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {31'd0, r_target_channel};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_channel <= 1'b0;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_target_channel <= pwdata[0];
        end
    end

    rfb_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in.valid),
        .i_in_channel     (i_in.input_channel),
        .i_target_channel (r_target_channel),
        .i_sts            (sts),
        .o_in_ready       (i_in.ready),
        .o_cmd            (cmd)
    );

    rfb_datapath #(
        .BANDS          (BANDS),
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ),
        .LOWEST_FREQ_HZ (LOWEST_FREQ_HZ)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_sample_value (i_in.sample_value),
        .o_sts          (sts),
        .o_out          (o_out)
    );

endmodule

/* verif/tb.sv */
// Self-checking bench for resonator_filter_bank: builds its own coefficient table,
// tracks resonator state per band and checks every band word against it.
// Depends on rfb_pkg and the rfb_in_if / rfb_out_if interfaces.
module tb;
    import rfb_pkg::*;

    typedef longint unsigned t_u64;

    localparam logic [2:0] AddrTarget = 3'd0;
    localparam logic [2:0] AddrUnused = 3'd4;
    localparam logic       ChLeft     = 1'b0;
    localparam logic       ChRight    = 1'b1;

    typedef struct {
        logic [BandW-1:0]        band;
        logic signed [RespW-1:0] resp;
        logic                    last;
    } t_band_word;

    class band_scoreboard;
        longint     a11[BankDepth], a12[BankDepth], a21[BankDepth], a22[BankDepth];
        longint     gain[BankDepth];
        longint     pos[BankDepth], vel[BankDepth];
        logic       target;
        t_band_word pending[$];
        int         errors;

        function new();
            t_u64 f;
            f = (t_u64'(DefLowestFreqHz) << 32) / 64'd1000;
            f = clip_freq(f);
            for (int i = 0; i < BankDepth; i++) begin
                pos[i] = 0;
                vel[i] = 0;
                build_band(i, f);
                f = step_freq(f);
            end
            target = ChLeft;
            errors = 0;
        endfunction

        static function t_u64 mq(t_u64 a, t_u64 b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return p[95:32];
        endfunction

        static function longint fl30(longint a, longint b);
            return (a * b) >>> 30;
        endfunction

        // floor(coef * v / 2^30) at full width
        static function longint scale(longint coef, longint v);
            logic signed [127:0] x, y, p;
            x = coef;
            y = v;
            p = x * y;
            p = p >>> 30;
            return p[63:0];
        endfunction

        static function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        static function t_u64 clip_freq(t_u64 f);
            if (f < FreqFloor) return FreqFloor;
            if (f > FreqCeil) return FreqCeil;
            return f;
        endfunction

        static function t_u64 step_freq(t_u64 f);
            t_u64 f2, f3, up, dn;
            f2 = mq(f, f);
            f3 = mq(f2, f);
            up = (64'd7 * f3) / 64'd10000 + (64'd10041 * f) / 64'd10000
               + (64'd6935 << 32) / 64'd10000000;
            dn = (64'd3 * f2) / 64'd1000;
            return clip_freq(up > dn ? up - dn : 64'd0);
        endfunction

        function void build_band(int i, t_u64 f);
            t_u64 w, w3, y, cand, y2, y4, y8, t, r, s, k, rho, frac, ang, a2, term, x, ex, e;
            longint ssum, csum, sn, cs, e30, k30, c30, s30, ks;
            w = mq(f, TwoPiQ32);
            w3 = mq(mq(w, w), w);
            y = 0;
            for (int b = 34; b >= 0; b--) begin
                cand = y | (64'd1 << b);
                y2 = mq(cand, cand);
                y4 = mq(y2, y2);
                y8 = mq(y4, y4);
                if (mq(y8, y2) <= w3) y = cand;
            end
            if (y == 0) y = 1;
            t = (64'd10 << 58) / (64'd127 * y);
            r = t > (OneQ32 >> 6) ? OneQ32 : (t << 6);
            s = root((OneQ32 - mq(r, r) / 64'd4) << 32);
            k = (r << 31) / s;
            rho = (f * 64'd1000) / t_u64'(DefSampleRateHz);
            frac = mq(rho, s) & 64'hFFFF_FFFF;
            ang = mq(frac & 64'h3FFF_FFFF, TwoPiQ32);
            a2 = mq(ang, ang);
            term = ang;
            ssum = longint'(ang);
            for (int n = 1; n <= 12; n++) begin
                term = mq(term, a2) / t_u64'((2 * n) * (2 * n + 1));
                ssum = (n % 2) ? ssum - longint'(term) : ssum + longint'(term);
            end
            term = OneQ32;
            csum = longint'(OneQ32);
            for (int n = 1; n <= 12; n++) begin
                term = mq(term, a2) / t_u64'((2 * n - 1) * (2 * n));
                csum = (n % 2) ? csum - longint'(term) : csum + longint'(term);
            end
            case (frac[31:30])
                2'd0: begin sn = ssum;  cs = csum;  end
                2'd1: begin sn = csum;  cs = -ssum; end
                2'd2: begin sn = -ssum; cs = -csum; end
                default: begin sn = -csum; cs = ssum; end
            endcase
            x = mq(mq(r, PiQ32), rho);
            if (x > DecayCap) x = DecayCap;
            ex = OneQ32;
            term = OneQ32;
            for (int n = 1; n <= 30; n++) begin
                term = mq(term, x) / t_u64'(n);
                ex = ex + term;
            end
            e = 64'hFFFF_FFFF_FFFF_FFFF / ex;
            e30 = longint'(e >> 2);
            k30 = longint'(k >> 2);
            c30 = cs >>> 2;
            s30 = sn >>> 2;
            ks = fl30(k30, s30);
            a11[i] = fl30(e30, c30 + ks);
            a12[i] = fl30(e30, s30);
            a22[i] = fl30(e30, c30 - ks);
            a21[i] = -fl30(fl30(e30, OneQ30 + fl30(k30, k30)), s30);
            gain[i] = longint'(mq(r, TwoPiQ32) >> 2);
        endfunction

        static function t_u64 root(t_u64 v_in);
            t_u64 v, res, bt;
            v = v_in;
            res = 0;
            bt = 64'd1 << 62;
            while (bt > v) bt = bt >> 2;
            while (bt != 0) begin
                if (v >= res + bt) begin
                    v = v - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
            return res;
        endfunction

        function void set_target(logic [31:0] value);
            target = value[0];
        endfunction

        // advance every band for one accepted target-channel sample and queue its band words
        function void note_sample(logic signed [SampleW-1:0] smp, logic ch);
            longint u, c, np, nq, resp;
            t_band_word bw;
            if (ch != target) return;
            u = longint'(smp) * 65536;
            for (int i = 0; i < DefBands; i++) begin
                c = clip(pos[i] - u, -(64'sd1 << 39), (64'sd1 << 39) - 1);
                np = clip(scale(a11[i], c) + scale(a12[i], vel[i]) + u,
                          -(64'sd1 << 39), (64'sd1 << 39) - 1);
                nq = clip(scale(a21[i], c) + scale(a22[i], vel[i]),
                          -(64'sd1 << 39), (64'sd1 << 39) - 1);
                resp = clip(scale(gain[i], np), -(64'sd1 << 31), (64'sd1 << 31) - 1);
                pos[i] = np;
                vel[i] = nq;
                bw.band = i[BandW-1:0];
                bw.resp = resp[RespW-1:0];
                bw.last = (i == DefBands - 1);
                pending = {pending, bw};
            end
        endfunction

        function void check_word(logic [BandW-1:0] band, logic signed [RespW-1:0] resp,
                                 logic last);
            t_band_word want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: band %0d resp %0d last %0b", band, resp, last);
                return;
            end
            want = pending.pop_front();
            if (band !== want.band || resp !== want.resp || last !== want.last) begin
                errors++;
                if (errors <= 10)
                    $display("band word mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                             want.band, want.resp, want.last, band, resp, last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rfb_in_if  in_ch ();
    rfb_out_if out_ch ();

    resonator_filter_bank dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    band_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_req;
    int  hold_left = 0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    initial begin
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // response side: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready)
            sb.check_word(out_ch.band_index, out_ch.band_response, out_ch.last_band);
        if (hold_req && hold_left == 0) begin
            hold_left <= 3000;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= (hold_left == 1);
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic cfg_write(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == AddrTarget) sb.set_target(value);
    endtask

    task automatic send_sample(logic signed [SampleW-1:0] smp, logic ch);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.sample_value <= smp;
        in_ch.input_channel <= ch;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_sample(smp, ch);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        // other-channel words leave no trace in the queue; let the block settle
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic signed [SampleW-1:0] pick_sample();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(signed'($urandom_range(255)) - 128);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic tgt;
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.sample_value = '0;
        in_ch.input_channel = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, steps and the ignored channel
        send_sample(16'sh7FFF, ChLeft);
        send_sample(16'sh7FFF, ChLeft);
        send_sample(16'sh8000, ChLeft);
        send_sample(16'sh8000, ChRight);
        send_sample(16'sh0000, ChLeft);
        send_sample(-16'sd1, ChLeft);
        send_sample(16'sd1, ChLeft);
        send_sample(16'sh5555, ChRight);
        send_sample(16'shAAAA, ChLeft);
        drain();
        // unmapped register and upper value bits must be ignored
        cfg_write(AddrUnused, 32'hFFFF_FFFF);
        cfg_write(AddrTarget, 32'hFFFF_FFFE);
        send_sample(16'sh7FFF, ChRight);
        send_sample(16'sh1234, ChLeft);
        drain();
        cfg_write(AddrTarget, 32'h0000_0003);
        send_sample(16'sh7FFF, ChLeft);
        send_sample(16'sh7FFF, ChRight);
        send_sample(16'sh8000, ChRight);
        send_sample(16'sh0000, ChRight);
        send_sample(16'shFFFF, ChRight);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            tgt = ph[0];
            cfg_write(AddrTarget, {$urandom} & 32'hFFFF_FFFE | 32'(tgt));
            for (int n = 0; n < 40; n++) begin
                if (ph == 0 && n == 5) hold_req = 1;
                if (ph == 0 && n == 9) hold_req = 0;
                // mostly drive the bank; the rest exercises the skip path
                send_sample(pick_sample(), ($urandom_range(99) < 80) ? tgt : ~tgt);
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
